// ===== rtl/spct_pkg.sv =====
// Shared constants and types for the shortest-path block.
`default_nettype none
package spct_pkg;
    localparam int MaxNodes  = 32;
    localparam int NodeBits  = 5;     // index bits for MaxNodes
    localparam int EdgeBits  = 16;
    localparam int TotBits   = 22;
    localparam logic [TotBits-1:0] TotalMax = 22'h3fffff;
    localparam logic [5:0] NodeCountReset = 6'd32;
    localparam int QDepth    = 4;
    localparam int QBits     = 2;

    typedef enum logic {
        ACT_EDGE  = 1'b0,
        ACT_SOLVE = 1'b1
    } action_t;

    // classified command handed from front to back
    typedef struct packed {
        logic                is_solve;
        logic                bad;       // endpoints outside range
        logic [NodeBits-1:0] a;
        logic [NodeBits-1:0] b;
        logic [EdgeBits-1:0] weight;
        logic [EdgeBits-1:0] cost;
    } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/spct_front.sv =====
// Front end: accepts input words, classifies them and queues commands.
`default_nettype none
module spct_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tuser,
    input  wire logic [55:0]   s_tdata,
    input  wire logic [5:0]    count,
    output logic               q_valid,
    input  wire logic          q_pop,
    output spct_pkg::cmd_t     q_cmd
);
    spct_pkg::cmd_t            mem_reg [spct_pkg::QDepth];
    logic [spct_pkg::QBits-1:0] wp_reg, rp_reg;
    logic [spct_pkg::QBits:0]   n_reg;
    spct_pkg::cmd_t            c;
    logic [5:0]                a6, b6, s6, e6;
    logic [5:0]                cnt;
    logic                      push;

    assign a6 = s_tdata[5:0];
    assign b6 = s_tdata[11:6];
    assign s6 = s_tdata[49:44];
    assign e6 = s_tdata[55:50];

    // nodes searched never exceed the matrix size
    assign cnt = (count > 6'(spct_pkg::MaxNodes)) ? 6'(spct_pkg::MaxNodes) : count;

    always_comb begin
        c.is_solve = (s_tuser == spct_pkg::ACT_SOLVE);
        if (c.is_solve) begin
            c.bad = (s6 >= cnt) || (e6 >= cnt);
            c.a = s6[spct_pkg::NodeBits-1:0];
            c.b = e6[spct_pkg::NodeBits-1:0];
        end else begin
            c.bad = (a6 >= 6'(spct_pkg::MaxNodes)) || (b6 >= 6'(spct_pkg::MaxNodes));
            c.a = a6[spct_pkg::NodeBits-1:0];
            c.b = b6[spct_pkg::NodeBits-1:0];
        end
        c.weight = s_tdata[27:12];
        c.cost = s_tdata[43:28];
    end

    assign s_tready = (n_reg != (spct_pkg::QBits+1)'(spct_pkg::QDepth));
    assign push = s_tvalid && s_tready;
    assign q_valid = (n_reg != '0);
    assign q_cmd = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= c;
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (q_pop) rp_reg <= rp_reg + 1'b1;
            n_reg <= n_reg + (spct_pkg::QBits+1)'(push) - (spct_pkg::QBits+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/spct_back.sv =====
// Back end: edge matrix writes, SPFA search sequencer and path emission.
`default_nettype none
module spct_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [5:0]     count,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire spct_pkg::cmd_t q_cmd,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic                m_tuser,
    output logic [55:0]         m_tdata,
    output logic                m_tlast
);
    localparam int NB = spct_pkg::NodeBits;
    localparam int N  = spct_pkg::MaxNodes;
    localparam int TB = spct_pkg::TotBits;
    localparam int AB = 2 * NB;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_EDGE2 = 11'b00000000100,
        S_POP   = 11'b00000001000,
        S_RD    = 11'b00000010000,
        S_REL   = 11'b00000100000,
        S_PATH  = 11'b00001000000,
        S_PRD   = 11'b00010000000,
        S_OUT   = 11'b00100000000,
        S_NEXT  = 11'b01000000000,
        S_BAD   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // adjacency memory, distance and cost together
    logic [2*spct_pkg::EdgeBits-1:0] adj_mem [N*N];
    logic [2*spct_pkg::EdgeBits-1:0] adj_rd_reg;
    logic [AB-1:0]  clr_reg;
    logic           clr_done;

    // per-node search state
    logic [TB-1:0]  bd_mem [N];
    logic [TB-1:0]  bc_mem [N];
    logic [NB-1:0]  pr_mem [N];
    logic [N-1:0]   reached_reg, queued_reg;
    logic [NB-1:0]  wq_mem [N];
    logic [NB-1:0]  qh_reg, qt_reg;
    logic [NB:0]    qn_reg;

    spct_pkg::cmd_t cmd_reg;
    logic [NB-1:0]  u_reg, v_reg, cur_reg;
    logic [TB-1:0]  du_reg, cu_reg, dv_reg, cv_reg;
    logic [TB-1:0]  tot_d_reg, tot_c_reg;
    logic [NB:0]    len_reg;
    logic [NB-1:0]  pr_rd_reg;

    logic [5:0]     cnt;
    logic [TB:0]    sd, sc;
    logic [TB-1:0]  nd, nc;
    logic           better, last_v, edge_ok;

    assign cnt = (count > 6'(N)) ? 6'(N) : count;
    assign clr_done = (clr_reg == {AB{1'b1}});

    assign sd = {1'b0, du_reg} + (TB+1)'(adj_rd_reg[spct_pkg::EdgeBits-1:0]);
    assign sc = {1'b0, cu_reg} + (TB+1)'(adj_rd_reg[2*spct_pkg::EdgeBits-1:spct_pkg::EdgeBits]);
    assign nd = sd[TB] ? spct_pkg::TotalMax : sd[TB-1:0];
    assign nc = sc[TB] ? spct_pkg::TotalMax : sc[TB-1:0];
    assign edge_ok = (adj_rd_reg[spct_pkg::EdgeBits-1:0] != '0);
    assign better = !reached_reg[v_reg] || (nd < dv_reg) || (nd == dv_reg && nc < cv_reg);
    assign last_v = ({1'b0, v_reg} + 6'd1 >= cnt);

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:   if (clr_done) state_next = S_IDLE;
            S_IDLE: begin
                if (q_valid) begin
                    if (!q_cmd.is_solve) state_next = q_cmd.bad ? S_IDLE : S_EDGE2;
                    else if (q_cmd.bad) state_next = S_BAD;
                    else if (q_cmd.a == q_cmd.b) state_next = S_PATH;
                    else state_next = S_POP;
                end
            end
            S_EDGE2: state_next = S_IDLE;
            S_POP:   state_next = (qn_reg == '0) ? S_PATH : S_RD;
            S_RD:    state_next = S_REL;
            S_REL:   state_next = last_v ? S_POP : S_RD;
            S_PATH:  state_next = reached_reg[cmd_reg.b] ? S_OUT : S_BAD;
            S_OUT:   if (m_tready) state_next = m_tlast ? S_IDLE : S_PRD;
            S_PRD:   state_next = S_NEXT;
            S_NEXT:  state_next = S_OUT;
            S_BAD:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        m_tvalid = (state_reg == S_OUT) || (state_reg == S_BAD);
        m_tdata = '0;
        m_tuser = 1'b0;
        m_tlast = 1'b1;
        if (state_reg == S_OUT) begin
            m_tdata[5:0] = 6'(cur_reg);
            m_tdata[27:6] = tot_d_reg;
            m_tdata[49:28] = tot_c_reg;
            m_tuser = 1'b1;
            m_tlast = (cur_reg == cmd_reg.a) || (len_reg + 1'b1 >= cnt);
        end
    end

    // adjacency memory port
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLR)
            adj_mem[clr_reg] <= '0;
        else if (state_reg == S_IDLE && q_valid && !q_cmd.is_solve && !q_cmd.bad)
            adj_mem[{q_cmd.a, q_cmd.b}] <= {q_cmd.cost, q_cmd.weight};
        else if (state_reg == S_EDGE2)
            adj_mem[{cmd_reg.b, cmd_reg.a}] <= {cmd_reg.cost, cmd_reg.weight};
        adj_rd_reg <= adj_mem[{u_reg, v_reg}];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
            u_reg <= q_cmd.a;
            cur_reg <= q_cmd.b;
            len_reg <= '0;
            du_reg <= '0;
            cu_reg <= '0;
            bd_mem[q_cmd.a] <= '0;
            bc_mem[q_cmd.a] <= '0;
            pr_mem[q_cmd.a] <= q_cmd.a;
            wq_mem[0] <= q_cmd.a;
        end
        if (state_reg == S_POP) begin
            u_reg <= wq_mem[qh_reg];
            du_reg <= bd_mem[wq_mem[qh_reg]];
            cu_reg <= bc_mem[wq_mem[qh_reg]];
            v_reg <= '0;
        end
        if (state_reg == S_RD) begin
            dv_reg <= bd_mem[v_reg];
            cv_reg <= bc_mem[v_reg];
        end
        if (state_reg == S_REL) begin
            if (edge_ok && better) begin
                bd_mem[v_reg] <= nd;
                bc_mem[v_reg] <= nc;
                pr_mem[v_reg] <= u_reg;
                if (!queued_reg[v_reg]) wq_mem[qt_reg] <= v_reg;
            end
            v_reg <= v_reg + 1'b1;
        end
        if (state_reg == S_PATH) begin
            tot_d_reg <= bd_mem[cmd_reg.b];
            tot_c_reg <= bc_mem[cmd_reg.b];
        end
        if (state_reg == S_PRD) pr_rd_reg <= pr_mem[cur_reg];
        if (state_reg == S_NEXT) begin
            cur_reg <= pr_rd_reg;
            len_reg <= len_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            reached_reg <= '0;
            queued_reg <= '0;
            qh_reg <= '0;
            qt_reg <= '0;
            qn_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_IDLE && q_valid && q_cmd.is_solve && !q_cmd.bad) begin
                // only the start node is reached and queued
                reached_reg <= N'(1) << q_cmd.a;
                queued_reg <= N'(1) << q_cmd.a;
                qh_reg <= '0;
                qt_reg <= NB'(1);
                qn_reg <= (NB+1)'(1);
            end
            if (state_reg == S_POP && qn_reg != '0) begin
                queued_reg[wq_mem[qh_reg]] <= 1'b0;
                qh_reg <= qh_reg + 1'b1;
                qn_reg <= qn_reg - 1'b1;
            end
            if (state_reg == S_REL && edge_ok && better) begin
                reached_reg[v_reg] <= 1'b1;
                if (!queued_reg[v_reg]) begin
                    queued_reg[v_reg] <= 1'b1;
                    qt_reg <= qt_reg + 1'b1;
                    qn_reg <= qn_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/shortest_path_cost_tiebreak.sv =====
// Top level of the shortest-path block with cost tiebreak.
// An edge word is taken into a four-entry command queue and written to the
// adjacency memory once per direction: a-to-b from S_IDLE, b-to-a in S_EDGE2.
// A solve word runs a queue-based search in the back end: each dequeued node
// is popped in S_POP, then min(node_count, 32) neighbors are scanned, each by a
// registered memory read in S_RD and a relaxation in S_REL. S_PATH fetches the
// totals, then each path node is emitted through S_OUT, S_PRD and S_NEXT, with
// S_OUT waiting on m_tready. s_tready drops while four commands wait. After
// reset a clearing pass zeroes all 1024 adjacency entries before commands run.
`default_nettype none
module shortest_path_cost_tiebreak (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action
    input  wire logic        s_tuser,
    // node_a, node_b, edge_distance, edge_cost, start_node, end_node
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // reachable
    output logic             m_tuser,
    // path_node, total_distance, total_cost
    output logic [55:0]      m_tdata,
    output logic             m_tlast
);
    logic [5:0]     node_count_reg;
    logic           q_valid, q_pop;
    spct_pkg::cmd_t q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) node_count_reg <= spct_pkg::NodeCountReset;
        else if (cfg_wr_en) node_count_reg <= cfg_wr_data;
    end

    spct_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .count(node_count_reg), .q_valid, .q_pop, .q_cmd
    );

    spct_back u_back (
        .aclk, .aresetn, .count(node_count_reg), .q_valid, .q_pop, .q_cmd,
        .m_tvalid, .m_tready, .m_tuser, .m_tdata, .m_tlast
    );
endmodule
`default_nettype wire

// ===== test/shortest_path_cost_tiebreak_tb.sv =====
// Self-checking testbench for the shortest-path block with cost tiebreak.
`timescale 1ns / 100ps
`default_nettype none
module shortest_path_cost_tiebreak_tb;
    localparam int WatchLimit = 400000;

    typedef struct {
        logic [5:0]  node;
        logic [21:0] tot_d;
        logic [21:0] tot_c;
        logic        reach;
        logic        last;
    } path_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tuser;
    logic [55:0] m_tdata;
    logic        m_tlast;

    shortest_path_cost_tiebreak uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // graph mirror and pending path words
    logic [15:0] edge_dist [spct_pkg::MaxNodes][spct_pkg::MaxNodes];
    logic [15:0] edge_cost [spct_pkg::MaxNodes][spct_pkg::MaxNodes];
    logic [5:0]  nodes_in_use = spct_pkg::NodeCountReset;
    path_word_t  pending_path[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    function automatic logic [21:0] sum_clamped(logic [21:0] x, logic [15:0] y);
        logic [22:0] s;
        s = {1'b0, x} + y;
        return (s > spct_pkg::TotalMax) ? spct_pkg::TotalMax : s[21:0];
    endfunction

    function automatic void expect_word(path_word_t w);
        pending_path.insert(pending_path.size(), w);
    endfunction

    // lexicographic SPFA from src, then queue the path words for dst
    task automatic predict_route(int src, int dst);
        int n, head, tail, used, u, len, cur;
        logic [21:0] bd [spct_pkg::MaxNodes];
        logic [21:0] bc [spct_pkg::MaxNodes];
        int pred [spct_pkg::MaxNodes];
        bit seen [spct_pkg::MaxNodes];
        bit inq [spct_pkg::MaxNodes];
        int fifo [spct_pkg::MaxNodes];
        int route [spct_pkg::MaxNodes];
        logic [21:0] nd, nc;
        bit better;
        path_word_t w;
        n = (nodes_in_use > spct_pkg::MaxNodes) ? spct_pkg::MaxNodes : nodes_in_use;
        w = '{node: 6'd0, tot_d: 22'd0, tot_c: 22'd0, reach: 1'b0, last: 1'b1};
        if (src >= n || dst >= n) begin
            expect_word(w);
            return;
        end
        for (int i = 0; i < spct_pkg::MaxNodes; i++) begin
            seen[i] = 0; inq[i] = 0; bd[i] = 0; bc[i] = 0; pred[i] = 0;
        end
        seen[src] = 1; pred[src] = src; inq[src] = 1;
        fifo[0] = src; head = 0; tail = 1; used = 1;
        while (used > 0) begin
            u = fifo[head];
            head = (head + 1) % spct_pkg::MaxNodes;
            used--;
            inq[u] = 0;
            for (int v = 0; v < n; v++) begin
                if (edge_dist[u][v] == 0) continue;
                nd = sum_clamped(bd[u], edge_dist[u][v]);
                nc = sum_clamped(bc[u], edge_cost[u][v]);
                better = !seen[v] || nd < bd[v] || (nd == bd[v] && nc < bc[v]);
                if (!better) continue;
                seen[v] = 1; bd[v] = nd; bc[v] = nc; pred[v] = u;
                if (!inq[v] && used < spct_pkg::MaxNodes) begin
                    fifo[tail] = v;
                    tail = (tail + 1) % spct_pkg::MaxNodes;
                    used++;
                    inq[v] = 1;
                end
            end
        end
        if (!seen[dst]) begin
            expect_word(w);
            return;
        end
        len = 0;
        cur = dst;
        while (len < n) begin
            route[len++] = cur;
            if (cur == src) break;
            cur = pred[cur] % spct_pkg::MaxNodes;
        end
        for (int k = 0; k < len; k++) begin
            w = '{node: route[k][5:0], tot_d: bd[dst], tot_c: bc[dst], reach: 1'b1,
                  last: (k + 1 == len)};
            expect_word(w);
        end
    endtask

    // one word on the input stream; valid stays high for a following word
    task automatic send_word(spct_pkg::action_t act, int a, int b, int d, int c,
                             int st, int en);
        logic [55:0] word;
        word = {en[5:0], st[5:0], c[15:0], d[15:0], b[5:0], a[5:0]};
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (act == spct_pkg::ACT_EDGE) begin
            if (a < spct_pkg::MaxNodes && b < spct_pkg::MaxNodes) begin
                edge_dist[a][b] = d[15:0]; edge_dist[b][a] = d[15:0];
                edge_cost[a][b] = c[15:0]; edge_cost[b][a] = c[15:0];
            end
        end else begin
            predict_route(st, en);
        end
        @(negedge aclk);
    endtask

    task automatic add_edge(int a, int b, int d, int c);
        send_word(spct_pkg::ACT_EDGE, a, b, d, c, $urandom_range(0, 62),
                  $urandom_range(0, 62));
    endtask

    task automatic run_query(int st, int en);
        send_word(spct_pkg::ACT_SOLVE, $urandom_range(0, 62), $urandom_range(0, 62),
                  $urandom, $urandom, st, en);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_path.size() != 0) @(negedge aclk);
        // queued edge writes finish without any output
        repeat (30) @(negedge aclk);
    endtask

    task automatic set_node_count(int v);
        drain();
        cfg_wr_en = 1'b1;
        cfg_wr_data = v[5:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        nodes_in_use = v[5:0];
    endtask

    task automatic test_directed();
        set_node_count(8);
        // two equal-distance routes 0->3, the one through 2 is cheaper
        add_edge(0, 1, 5, 10);
        add_edge(1, 3, 5, 10);
        add_edge(0, 2, 5, 3);
        add_edge(2, 3, 5, 3);
        run_query(0, 3);
        // full tie through 4: first found predecessor is kept
        add_edge(0, 4, 5, 3);
        add_edge(4, 3, 5, 3);
        run_query(3, 0);
        add_edge(5, 5, 1, 1);           // self loop
        add_edge(62, 1, 1, 1);          // endpoint out of range, ignored
        add_edge(6, 7, 65535, 65535);
        add_edge(5, 6, 65535, 0);
        run_query(5, 7);
        run_query(4, 4);                // start equals end
        run_query(0, 7);                // unreachable
        run_query(0, 9);                // end outside searched nodes
        run_query(62, 0);               // start outside searched nodes
        add_edge(2, 3, 0, 0);           // remove edge
        run_query(0, 3);
    endtask

    task automatic test_node_count_extremes();
        set_node_count(1);
        run_query(0, 0);
        run_query(0, 1);
        set_node_count(0);
        run_query(0, 0);
        set_node_count(63);
        // long chain over all nodes with big weights
        for (int i = 0; i < spct_pkg::MaxNodes - 1; i++)
            add_edge(i, i + 1, 65535, 65535 - i);
        run_query(0, 31);
        run_query(31, 0);
    endtask

    task automatic test_random(int words, int count);
        int n, a, b;
        set_node_count(count);
        n = (count > spct_pkg::MaxNodes) ? spct_pkg::MaxNodes : ((count == 0) ? 1 : count);
        for (int i = 0; i < words; i++) begin
            if ($urandom_range(99) < 72) begin
                if ($urandom_range(9) == 0) begin
                    a = $urandom_range(0, 62); b = $urandom_range(0, 62);
                end else begin
                    a = $urandom_range(0, n - 1); b = $urandom_range(0, n - 1);
                end
                add_edge(a, b, ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 20) *
                         (($urandom_range(3) == 0) ? 3000 : 1), $urandom);
            end else if ($urandom_range(9) == 0) begin
                run_query($urandom_range(0, 62), $urandom_range(0, 62));
            end else begin
                run_query($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            end
        end
    endtask

    task automatic test_full_drain_pause();
        drain();
        run_query(0, $urandom_range(1, 7));
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        path_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_path.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected path word %h", m_tdata);
            end else begin
                want = pending_path.pop_front();
                if (m_tdata[5:0] !== want.node || m_tdata[27:6] !== want.tot_d ||
                    m_tdata[49:28] !== want.tot_c || m_tuser !== want.reach ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("path word: want node %0d dist %0d cost %0d %s%0d %s%0d,",
                                 want.node, want.tot_d, want.tot_c, "reach ", want.reach,
                                 "last ", want.last,
                                 " got node %0d dist %0d cost %0d reach %0d last %0d",
                                 m_tdata[5:0], m_tdata[27:6], m_tdata[49:28], m_tuser,
                                 m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < spct_pkg::MaxNodes; i++)
            for (int j = 0; j < spct_pkg::MaxNodes; j++) begin
                edge_dist[i][j] = 0;
                edge_cost[i][j] = 0;
            end
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        send_idle_pct = 20; recv_idle_pct = 84;
        test_directed();
        test_node_count_extremes();
        test_random(25, 8);
        send_idle_pct = 84; recv_idle_pct = 20;
        test_random(25, 16);
        test_full_drain_pause();
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(25, $urandom_range(2, 32));
        drain();
        repeat (50) @(negedge aclk);
        if (mismatches == 0 && pending_path.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
